FILE: hdl/i2cbm_pkg.sv
package i2cbm_pkg;

	// Command codes on the mode field
	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_STOP  = 3'd2;
	localparam logic [2:0] MODE_ACK   = 3'd3;
	localparam logic [2:0] MODE_NACK  = 3'd4;
	localparam logic [2:0] MODE_WACK  = 3'd5;
	localparam logic [2:0] MODE_SEND  = 3'd6;
	localparam logic [2:0] MODE_READ  = 3'd7;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

	localparam int CFG_W   = 10;
	localparam int DELAY_W = 14;

	localparam logic [CFG_W-1:0] TICKS_PER_US_RST   = 10'd72;
	localparam logic [CFG_W-1:0] ACK_POLL_LIMIT_RST = 10'd250;

	// Sequencer phases: start, stop, ack out, ack wait, byte send, byte read
	typedef enum logic [4:0] {
		PH_IDLE = 5'd0,
		PH_S0   = 5'd1,
		PH_S1   = 5'd2,
		PH_S2   = 5'd3,
		PH_P0   = 5'd4,
		PH_P1   = 5'd5,
		PH_P2   = 5'd6,
		PH_A0   = 5'd7,
		PH_A1   = 5'd8,
		PH_A2   = 5'd9,
		PH_W0   = 5'd10,
		PH_W1   = 5'd11,
		PH_W2   = 5'd12,
		PH_B0   = 5'd13,
		PH_B1   = 5'd14,
		PH_B2   = 5'd15,
		PH_B3   = 5'd16,
		PH_R0   = 5'd17,
		PH_R1   = 5'd18,
		PH_R2   = 5'd19,
		PH_R3   = 5'd20
	} phase_t;

	// Architectural state of the sequencer
	typedef struct packed {
		phase_t             phase;
		logic [DELAY_W-1:0] delay;
		logic [3:0]         bits;
		logic [7:0]         shift;
		logic [CFG_W-1:0]   poll;
		logic               scl;
		logic               sda;
		logic               sda_oe;
		logic               ack_choice;
		logic               timeout;
		logic [7:0]         rx;
	} seq_state_t;

	localparam seq_state_t STATE_RST = '{
		phase:      PH_IDLE,
		delay:      '0,
		bits:       '0,
		shift:      '0,
		poll:       '0,
		scl:        1'b1,
		sda:        1'b1,
		sda_oe:     1'b1,
		ack_choice: 1'b0,
		timeout:    1'b0,
		rx:         '0
	};

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// Delay in ticks for a number of microseconds
	function automatic logic [DELAY_W-1:0] us_ticks(input logic [CFG_W-1:0] t,
		input logic [2:0] us);
		logic [DELAY_W-1:0] prod;
		prod = DELAY_W'(t) * DELAY_W'(us);
		return prod;
	endfunction

endpackage

FILE: hdl/i2cbm_cfg.sv
module i2cbm_cfg
	import i2cbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output logic [CFG_W-1:0]     ticks_per_us,
	output logic [CFG_W-1:0]     ack_poll_limit
);

	logic [CFG_W-1:0] ticks_q;
	logic [CFG_W-1:0] limit_q;

	// Register file, one write beat per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= TICKS_PER_US_RST;
			limit_q <= ACK_POLL_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_TICKS_PER_US:   ticks_q <= wr_data;
				CFG_ACK_POLL_LIMIT: limit_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign ticks_per_us   = ticks_q;
	assign ack_poll_limit = limit_q;

endmodule

FILE: hdl/i2cbm_step.sv
module i2cbm_step
	import i2cbm_pkg::*;
(
	input  seq_state_t       cur,
	input  logic [2:0]       mode,
	input  logic [7:0]       data_byte,
	input  logic             ack_after_read,
	input  logic             sda_in,
	input  logic [CFG_W-1:0] ticks_per_us,
	input  logic [CFG_W-1:0] ack_poll_limit,
	output seq_state_t       nxt,
	output logic             done
);

	logic [CFG_W-1:0]   t_eff;
	logic [DELAY_W-1:0] d1, d2, d5, d6;

	// A zero tick rate counts as one
	assign t_eff = (ticks_per_us == '0) ? CFG_W'(1) : ticks_per_us;
	assign d1 = us_ticks(t_eff, 3'd1);
	assign d2 = us_ticks(t_eff, 3'd2);
	assign d5 = us_ticks(t_eff, 3'd5);
	assign d6 = us_ticks(t_eff, 3'd6);

	// One tick of the sequencer; each tick runs at most one phase
	always_comb begin
		phase_t ph;
		logic   run;
		nxt  = cur;
		done = 1'b0;
		ph   = cur.phase;
		run  = 1'b0;

		if (cur.phase == PH_IDLE) begin
			run = (mode != MODE_NONE);
			case (mode)
				MODE_START: ph = PH_S0;
				MODE_STOP:  ph = PH_P0;
				MODE_ACK: begin
					ph = PH_A0;
					nxt.ack_choice = 1'b1;
				end
				MODE_NACK: begin
					ph = PH_A0;
					nxt.ack_choice = 1'b0;
				end
				MODE_WACK:  ph = PH_W0;
				MODE_SEND: begin
					ph = PH_B0;
					nxt.shift = data_byte;
				end
				MODE_READ: begin
					ph = PH_R0;
					nxt.ack_choice = ack_after_read;
				end
				default: ph = PH_IDLE;
			endcase
		end else if (cur.delay > DELAY_W'(1)) begin
			nxt.delay = cur.delay - DELAY_W'(1);
		end else begin
			nxt.delay = '0;
			run = 1'b1;
		end

		if (run) begin
			case (ph)
				PH_S0: begin
					nxt.sda_oe = 1'b1;
					nxt.sda    = 1'b1;
					nxt.scl    = 1'b1;
					nxt.phase  = PH_S1;
					nxt.delay  = d5;
				end
				PH_S1: begin
					nxt.sda   = 1'b0;
					nxt.phase = PH_S2;
					nxt.delay = d6;
				end
				PH_S2: begin
					nxt.scl   = 1'b0;
					nxt.phase = PH_IDLE;
					done      = 1'b1;
				end
				PH_P0: begin
					nxt.sda_oe = 1'b1;
					nxt.sda    = 1'b0;
					nxt.scl    = 1'b1;
					nxt.phase  = PH_P1;
					nxt.delay  = d6;
				end
				PH_P1: begin
					nxt.sda   = 1'b1;
					nxt.phase = PH_P2;
					nxt.delay = d6;
				end
				PH_P2: begin
					nxt.phase = PH_IDLE;
					done      = 1'b1;
				end
				PH_A0: begin
					nxt.scl    = 1'b0;
					nxt.sda_oe = 1'b1;
					nxt.sda    = ~nxt.ack_choice;
					nxt.phase  = PH_A1;
					nxt.delay  = d2;
				end
				PH_A1: begin
					nxt.scl   = 1'b1;
					nxt.phase = PH_A2;
					nxt.delay = d5;
				end
				PH_A2: begin
					nxt.scl   = 1'b0;
					nxt.phase = PH_IDLE;
					done      = 1'b1;
				end
				PH_W0: begin
					nxt.sda_oe = 1'b0;
					nxt.sda    = 1'b1;
					nxt.poll   = '0;
					nxt.phase  = PH_W1;
					nxt.delay  = d1;
				end
				PH_W1: begin
					nxt.scl   = 1'b1;
					nxt.phase = PH_W2;
					nxt.delay = d1;
				end
				PH_W2: begin
					if (!sda_in) begin
						// slave acked
						nxt.scl     = 1'b0;
						nxt.timeout = 1'b0;
						nxt.phase   = PH_IDLE;
						done        = 1'b1;
					end else if (cur.poll >= ack_poll_limit) begin
						// give up and issue a stop at once
						nxt.timeout = 1'b1;
						nxt.sda_oe  = 1'b1;
						nxt.sda     = 1'b0;
						nxt.scl     = 1'b1;
						nxt.phase   = PH_P1;
						nxt.delay   = d6;
					end else begin
						nxt.poll = cur.poll + CFG_W'(1);
					end
				end
				PH_B0, PH_B1: begin
					if (ph == PH_B0) begin
						nxt.sda_oe = 1'b1;
						nxt.scl    = 1'b0;
						nxt.bits   = '0;
					end
					nxt.sda   = nxt.shift[7];
					nxt.shift = {nxt.shift[6:0], 1'b0};
					nxt.scl   = 1'b1;
					nxt.phase = PH_B2;
					nxt.delay = d2;
				end
				PH_B2: begin
					nxt.scl   = 1'b0;
					nxt.phase = PH_B3;
					nxt.delay = d2;
				end
				PH_B3: begin
					nxt.bits = cur.bits + 4'd1;
					if (nxt.bits < BITS_PER_BYTE) begin
						nxt.sda   = cur.shift[7];
						nxt.shift = {cur.shift[6:0], 1'b0};
						nxt.scl   = 1'b1;
						nxt.phase = PH_B2;
						nxt.delay = d2;
					end else begin
						nxt.phase = PH_IDLE;
						done      = 1'b1;
					end
				end
				PH_R0, PH_R1: begin
					if (ph == PH_R0) begin
						nxt.sda_oe = 1'b0;
						nxt.bits   = '0;
						nxt.shift  = '0;
					end
					nxt.scl   = 1'b0;
					nxt.phase = PH_R2;
					nxt.delay = d2;
				end
				PH_R2: begin
					nxt.scl   = 1'b1;
					nxt.shift = {cur.shift[6:0], sda_in};
					nxt.phase = PH_R3;
					nxt.delay = d1;
				end
				PH_R3: begin
					nxt.bits = cur.bits + 4'd1;
					if (nxt.bits < BITS_PER_BYTE) begin
						nxt.scl   = 1'b0;
						nxt.phase = PH_R2;
						nxt.delay = d2;
					end else begin
						// byte in, follow with the master ack or nack
						nxt.rx     = cur.shift;
						nxt.scl    = 1'b0;
						nxt.sda_oe = 1'b1;
						nxt.sda    = ~cur.ack_choice;
						nxt.phase  = PH_A1;
						nxt.delay  = d2;
					end
				end
				default: nxt.phase = PH_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/i2c_bit_level_master.sv
// I2C master pin sequencer. Each input beat is one tick of the sequencer: it
// carries the sampled SDA level and, while the block is idle, a command
// (start, stop, master ack/nack, wait for slave ack, send byte, read byte
// with trailing ack or nack). Each input beat yields exactly one output beat
// with the pin levels after that tick plus busy, done, the last read byte and
// the ack timeout flag. Microsecond delays last n * ticks_per_us ticks (zero
// is taken as one). A beat is taken each cycle the result slot is empty or
// out_ready holds: the next tick is computed combinationally from the state
// register and written back to it: one tick per clock while out_ready holds.
// Configuration writes are always accepted and should be made while idle.
module i2c_bit_level_master
	import i2cbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           mode,
	input  logic [7:0]           data_byte,
	input  logic                 ack_after_read,
	input  logic                 sda_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 scl_out,
	output logic                 sda_out,
	output logic                 sda_output_enable,
	output logic                 busy_res,
	output logic                 done_res,
	output logic [7:0]           received_byte,
	output logic                 ack_failed
);

	logic [CFG_W-1:0] ticks_per_us;
	logic [CFG_W-1:0] ack_poll_limit;
	seq_state_t       state_q;
	seq_state_t       state_nxt;
	logic             done_nxt;
	logic             done_q;
	logic             out_valid_q;
	logic             accept;

	assign cfg_ready = 1'b1;

	i2cbm_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (cfg_valid),
		.wr_index       (cfg_index),
		.wr_data        (cfg_data),
		.ticks_per_us   (ticks_per_us),
		.ack_poll_limit (ack_poll_limit)
	);

	i2cbm_step u_step (
		.cur            (state_q),
		.mode           (mode),
		.data_byte      (data_byte),
		.ack_after_read (ack_after_read),
		.sda_in         (sda_in),
		.ticks_per_us   (ticks_per_us),
		.ack_poll_limit (ack_poll_limit),
		.nxt            (state_nxt),
		.done           (done_nxt)
	);

	// Take a beat when the result slot is empty or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// State and result registers advance together on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RST;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_nxt;
				done_q  <= done_nxt;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result beat is read from the state, done and valid registers
	assign out_valid         = out_valid_q;
	assign scl_out           = state_q.scl;
	assign sda_out           = state_q.sda;
	assign sda_output_enable = state_q.sda_oe;
	assign busy_res          = (state_q.phase != PH_IDLE);
	assign done_res          = done_q;
	assign received_byte     = state_q.rx;
	assign ack_failed        = state_q.timeout;

endmodule
